[hdl/dhte_pkg.sv]
// Package for the double-hash table engine: sizes, slot and status codes,
// and the key hash byte-term helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dhte_pkg;
	localparam int Capacity  = 64;
	localparam int KeyBytes  = 4;
	localparam int IdxW      = $clog2(Capacity);
	localparam int HashW     = 15;
	localparam int CntW      = IdxW + 1;
	localparam int GoldenQ16 = 40503;

	typedef logic [IdxW-1:0]  idx_t;
	typedef logic [HashW-1:0] hash_t;
	typedef logic [CntW-1:0]  cnt_t;

	typedef enum logic [1:0] {SLOT_EMPTY = 2'd0, SLOT_FILLED = 2'd1, SLOT_TOMB = 2'd2}
		slot_st_t;
	typedef enum logic [1:0] {FN_PUT = 2'd0, FN_GET = 2'd1, FN_REMOVE = 2'd2,
		FN_NONE = 2'd3} func_t;
	typedef enum logic [1:0] {RS_DONE = 2'd0, RS_REPLACED = 2'd1, RS_MISSING = 2'd2,
		RS_FULL = 2'd3} res_t;

	typedef enum logic [2:0] {ST_IDLE, ST_CLEAR, ST_HASH, ST_READ, ST_CHECK, ST_WRITE,
		ST_RESULT} fsm_t;

	// one slot as stored in the memory
	typedef struct packed {
		slot_st_t    st;
		hash_t       hash;
		logic [31:0] key;
		logic [31:0] value;
	} slot_t;

	// byte weight (KeyBytes-i)<<5 times ((97+b) mod 90), b < 256
	function automatic hash_t byte_term(input logic [7:0] b, input int i);
		logic [8:0] s;
		logic [8:0] m;
		s = 9'd97 + {1'b0, b};
		if (s >= 9'd270)      m = s - 9'd270;
		else if (s >= 9'd180) m = s - 9'd180;
		else if (s >= 9'd90)  m = s - 9'd90;
		else                  m = s;
		return hash_t'({6'd0, m} * hash_t'((KeyBytes - i) << 5));
	endfunction
endpackage
`default_nettype wire

[hdl/double_hash_table_engine_unit.sv]
// Double-hash table engine, top level. Depends on dhte_pkg, dhte_slot_ram.
// From accept to m_tvalid: HASH, then READ and CHECK for each probe (P = probes,
// 1..64), then WRITE and RESULT; an unused op code skips the walk from HASH to
// RESULT. One item at a time; the slot memory has a single read port.
// Result beat sits in an output register; next item is taken once it drains.
// Reset: asynchronous; then a clearing pass marks all slots empty before the
// first item is accepted.
`timescale 1ns / 1ps
`default_nettype none
module double_hash_table_engine_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [71:0] s_tdata,   // func[1:0], key[33:2], value[65:34], zero pad
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata    // status[1:0], read_value[33:2], key_count[40:34], pad
);
	dhte_pkg::fsm_t state_q, state_d;
	dhte_pkg::idx_t clr_q, idx_q, step_q, free_q, probe_q;
	logic           probes_done_q;
	logic           has_free_q;
	logic [1:0]     func_q;
	logic [31:0]    key_q, value_q;
	dhte_pkg::hash_t hash_q;
	dhte_pkg::cnt_t live_q;
	logic [1:0]     status_q;
	logic [31:0]    rd_q;
	logic           out_v_q;

	logic             we;
	dhte_pkg::idx_t   waddr, raddr;
	dhte_pkg::slot_t  wdata, rdata;

	dhte_slot_ram u_ram (.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata));

	logic           in_acc;
	dhte_pkg::hash_t h_c;
	logic           hit_c, is_last_c;

	assign s_tready = (state_q == dhte_pkg::ST_IDLE) && !out_v_q;
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = out_v_q;
	assign m_tdata  = {7'd0, live_q, rd_q, status_q};

	always_comb begin
		h_c = '0;
		for (int i = 0; i < dhte_pkg::KeyBytes; i++) begin
			h_c = h_c + dhte_pkg::byte_term(key_q[8*i +: 8], i);
		end
	end
	assign hit_c = (rdata.st == dhte_pkg::SLOT_FILLED) && (rdata.hash == hash_q)
		&& (rdata.key == key_q);
	assign is_last_c = probes_done_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dhte_pkg::ST_CLEAR: if (&clr_q) state_d = dhte_pkg::ST_IDLE;
			dhte_pkg::ST_IDLE:  if (in_acc) state_d = dhte_pkg::ST_HASH;
			dhte_pkg::ST_HASH:  state_d = (func_q == dhte_pkg::FN_NONE) ?
				dhte_pkg::ST_RESULT : dhte_pkg::ST_READ;
			dhte_pkg::ST_READ:  state_d = dhte_pkg::ST_CHECK;
			dhte_pkg::ST_CHECK: begin
				if (hit_c || rdata.st == dhte_pkg::SLOT_EMPTY || is_last_c)
					state_d = dhte_pkg::ST_WRITE;
				else
					state_d = dhte_pkg::ST_READ;
			end
			dhte_pkg::ST_WRITE:  state_d = dhte_pkg::ST_RESULT;
			dhte_pkg::ST_RESULT: state_d = dhte_pkg::ST_IDLE;
			default:             state_d = dhte_pkg::ST_IDLE;
		endcase
	end

	// decision made in CHECK, applied in WRITE
	logic        found_q;
	dhte_pkg::idx_t pos_q;

	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = '{st: dhte_pkg::SLOT_FILLED, hash: hash_q, key: key_q, value: value_q};
		raddr = idx_q;
		unique case (state_q)
			dhte_pkg::ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata.st = dhte_pkg::SLOT_EMPTY;
			end
			dhte_pkg::ST_WRITE: begin
				if (func_q == dhte_pkg::FN_PUT && found_q) begin
					we = 1'b1;
				end else if (func_q == dhte_pkg::FN_PUT && has_free_q) begin
					we    = 1'b1;
					waddr = free_q;
				end else if (func_q == dhte_pkg::FN_REMOVE && found_q) begin
					we = 1'b1;
					wdata.st = dhte_pkg::SLOT_TOMB;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dhte_pkg::ST_CLEAR;
			clr_q   <= '0;
			out_v_q <= 1'b0;
			live_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == dhte_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (m_tvalid && m_tready) out_v_q <= 1'b0;
			if (state_q == dhte_pkg::ST_RESULT) out_v_q <= 1'b1;
			if (state_q == dhte_pkg::ST_WRITE) begin
				if (func_q == dhte_pkg::FN_PUT && !found_q && has_free_q)
					live_q <= live_q + 1'b1;
				else if (func_q == dhte_pkg::FN_REMOVE && found_q)
					live_q <= live_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			dhte_pkg::ST_IDLE: begin
				func_q  <= s_tdata[1:0];
				key_q   <= s_tdata[33:2];
				value_q <= s_tdata[65:34];
			end
			dhte_pkg::ST_HASH: begin
				hash_q        <= h_c;
				idx_q         <= dhte_pkg::idx_t'((32'({17'd0, h_c} * 32'(dhte_pkg::GoldenQ16))
					>> 16) >> dhte_pkg::IdxW);
				step_q        <= dhte_pkg::idx_t'({h_c, 1'b1});
				probe_q       <= '0;
				probes_done_q <= 1'b0;
				has_free_q    <= 1'b0;
				found_q       <= 1'b0;
				status_q      <= dhte_pkg::RS_MISSING;
				rd_q          <= '0;
			end
			dhte_pkg::ST_CHECK: begin
				pos_q <= idx_q;
				if (hit_c) begin
					found_q <= 1'b1;
					rd_q    <= rdata.value;
				end else if (rdata.st != dhte_pkg::SLOT_FILLED && !has_free_q) begin
					has_free_q <= 1'b1;
					free_q     <= idx_q;
				end
				idx_q         <= idx_q + step_q;
				probe_q       <= probe_q + 1'b1;
				probes_done_q <= &(probe_q + 1'b1);
			end
			dhte_pkg::ST_WRITE: begin
				unique case (func_q)
					dhte_pkg::FN_PUT: begin
						if (found_q) status_q <= dhte_pkg::RS_REPLACED;
						else if (has_free_q) status_q <= dhte_pkg::RS_DONE;
						else status_q <= dhte_pkg::RS_FULL;
					end
					dhte_pkg::FN_GET: if (found_q) status_q <= dhte_pkg::RS_DONE;
					dhte_pkg::FN_REMOVE: begin
						rd_q <= '0;
						if (found_q) status_q <= dhte_pkg::RS_DONE;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// pad bits of the input beat carry nothing
	logic unused_c;
	assign unused_c = ^s_tdata[71:66];

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != dhte_pkg::ST_IDLE) |-> !s_tready) else $error("accept while busy");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= dhte_pkg::cnt_t'(dhte_pkg::Capacity)) else $error("key count overflow");
	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dhte_pkg::ST_RESULT) |=> m_tvalid) else $error("result lost");
`endif
endmodule
`default_nettype wire

[hdl/dhte_slot_ram.sv]
// Slot memory of the double-hash table engine: one write port, one
// registered read port. Depends on dhte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dhte_slot_ram (
	input  wire              clk,
	input  wire              we,
	input  dhte_pkg::idx_t   waddr,
	input  dhte_pkg::slot_t  wdata,
	input  dhte_pkg::idx_t   raddr,
	output dhte_pkg::slot_t  rdata
);
	dhte_pkg::slot_t mem [dhte_pkg::Capacity];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
